FILE: hdl/csvt_pkg.sv
package csvt_pkg;

   // Input item: operation code and text byte
   typedef struct packed {
      logic       operation;
      logic [7:0] in_byte;
   } req_type;

   // Result item
   typedef struct packed {
      logic [7:0] out_char;
      logic       has_char;
      logic       field_end;
      logic       row_end;
      logic       ws_overflow;
      logic       last;
   } rsp_type;

   // Operation codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   // Configuration register indexes
   localparam int          CSR_INDEX_W = 2;
   localparam logic [1:0]  CSR_DELIMITER = 2'd0;
   localparam logic [1:0]  CSR_QUOTE     = 2'd1;

   // Reset values of the configuration registers
   localparam logic [7:0] DELIMITER_RESET = 8'd44;
   localparam logic [7:0] QUOTE_RESET     = 8'd34;

   // Fixed characters
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_TAB     = 8'd9;

   // What an accepted item produces
   localparam logic [1:0] KIND_NONE = 2'd0;  // no result
   localparam logic [1:0] KIND_MARK = 2'd1;  // one field/row end mark
   localparam logic [1:0] KIND_CHAR = 2'd2;  // one content byte, nothing held
   localparam logic [1:0] KIND_HELD = 2'd3;  // held whitespace, then content byte

   // Controller to datapath
   typedef struct packed {
      logic take;   // item accepted this cycle
      logic pop;    // send the oldest held whitespace byte
      logic emit;   // send the latched content byte as the final result
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic       slot_free;  // output register can load this cycle
      logic [1:0] kind;       // decode of the item on the input port
      logic       held_one;   // exactly one whitespace byte still held
   } sts_type;

endpackage

FILE: hdl/csv_field_tokenizer.sv
// Channel  Direction  Handshake              Payload
// req_     in         req_valid / req_stall  req_data  (operation, in_byte)
// rsp_     out        rsp_valid / rsp_stall  rsp_data  (out_char .. last)
// csr_     in         csr_valid / csr_ready  csr_index, csr_data
//
// One item per cycle, while rsp_ does not stall, when it gives no result or a single result.
// Content behind held whitespace: the item is accepted, then one held byte per cycle
// through the output register while rsp_ does not stall, then the content byte.
// Synchronous active-high reset; the whitespace buffer is not cleared.
// A stall on rsp_ holds the output register and the input stalls with it.
module csv_field_tokenizer #(
   parameter int WS_HOLD_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  csvt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output csvt_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [csvt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]        csr_data
);

   csvt_pkg::cmd_type cmd;
   csvt_pkg::sts_type sts;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   csvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   csvt_datapath #(
      .WS_HOLD_DEPTH (WS_HOLD_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

FILE: hdl/csvt_datapath.sv
module csvt_datapath #(
   parameter int WS_HOLD_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  csvt_pkg::req_type req_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [csvt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]        csr_data,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output csvt_pkg::rsp_type rsp_data,
   input  csvt_pkg::cmd_type cmd,
   output csvt_pkg::sts_type sts
);

   localparam int CNT_W = $clog2(WS_HOLD_DEPTH + 1);
   localparam int IDX_W = (WS_HOLD_DEPTH > 1) ? $clog2(WS_HOLD_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WS_HOLD_DEPTH);

   // Configuration registers
   logic [7:0] delim_ff, quote_ff;

   // Parsing state
   logic iq_ff, iq_in;
   logic qs_ff, qs_in;
   logic fhc_ff, fhc_in;
   logic ls_ff, ls_in;
   logic ovf_ff, ovf_in;
   logic [CNT_W-1:0] held_ff, held_in;

   // Held whitespace, 1 = tab; oldest byte sits at bit 0
   logic [WS_HOLD_DEPTH-1:0] ws_ff;
   logic ws_wr;
   logic ws_bit;

   // Content byte waiting behind a flush
   logic [7:0] char_ff;

   // Output register
   logic    rsp_valid_ff;
   csvt_pkg::rsp_type rsp_ff;

   // Decode of the item on the input port
   logic [1:0] kind;
   logic       mark_re;
   logic       unq;
   logic       is_content;
   logic [7:0] b;

   always_comb begin
      b          = req_data.in_byte;
      kind       = csvt_pkg::KIND_NONE;
      mark_re    = 1'b0;
      unq        = 1'b0;
      is_content = 1'b0;
      iq_in      = iq_ff;
      qs_in      = qs_ff;
      fhc_in     = fhc_ff;
      ls_in      = ls_ff;
      held_in    = held_ff;
      ovf_in     = ovf_ff;
      ws_wr      = 1'b0;
      ws_bit     = (b == csvt_pkg::CH_TAB);

      if (req_data.operation == csvt_pkg::OP_END) begin
         // end of input: close an open row, then clear the parsing state but the overflow flag
         if (ls_ff) begin
            kind    = csvt_pkg::KIND_MARK;
            mark_re = 1'b1;
         end
         iq_in   = 1'b0;
         qs_in   = 1'b0;
         ls_in   = 1'b0;
         fhc_in  = 1'b0;
         held_in = '0;
      end else if (iq_ff) begin
         ls_in = 1'b1;
         if (qs_ff) begin
            qs_in = 1'b0;
            if (b == quote_ff) begin
               is_content = 1'b1;       // doubled quote
            end else begin
               iq_in = 1'b0;            // section closes, byte handled outside
               unq   = 1'b1;
            end
         end else if (b == quote_ff) begin
            qs_in = 1'b1;
         end else begin
            is_content = 1'b1;
         end
      end else begin
         unq = 1'b1;
      end

      // Outside quotes: delimiter, newline, quote, whitespace, content
      if (unq) begin
         if (b == delim_ff) begin
            fhc_in  = 1'b0;
            held_in = '0;
            ls_in   = 1'b1;
            kind    = csvt_pkg::KIND_MARK;
         end else if (b == csvt_pkg::CH_NEWLINE) begin
            fhc_in  = 1'b0;
            held_in = '0;
            ls_in   = 1'b0;
            kind    = csvt_pkg::KIND_MARK;
            mark_re = 1'b1;
         end else begin
            ls_in = 1'b1;
            if (b == quote_ff) begin
               iq_in  = 1'b1;
               fhc_in = 1'b1;
            end else if (b == csvt_pkg::CH_SPACE || b == csvt_pkg::CH_TAB) begin
               if (fhc_ff) begin
                  if (held_ff < DEPTH_CNT) begin
                     ws_wr   = 1'b1;
                     held_in = held_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end else begin
               is_content = 1'b1;
            end
         end
      end

      // Content: direct, or behind held whitespace (count drains by pops)
      if (is_content) begin
         fhc_in = 1'b1;
         kind   = (held_ff == '0) ? csvt_pkg::KIND_CHAR : csvt_pkg::KIND_HELD;
      end
   end

   // Status to the controller
   assign sts.slot_free = !rsp_valid_ff || !rsp_stall;
   assign sts.kind      = kind;
   assign sts.held_one  = (held_ff == CNT_W'(1));

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= csvt_pkg::DELIMITER_RESET;
         quote_ff <= csvt_pkg::QUOTE_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == csvt_pkg::CSR_DELIMITER) begin
            delim_ff <= csr_data;
         end else if (csr_index == csvt_pkg::CSR_QUOTE) begin
            quote_ff <= csr_data;
         end
      end
   end

   // Parsing state and held count
   always_ff @(posedge clock) begin
      if (reset) begin
         iq_ff   <= 1'b0;
         qs_ff   <= 1'b0;
         fhc_ff  <= 1'b0;
         ls_ff   <= 1'b0;
         ovf_ff  <= 1'b0;
         held_ff <= '0;
      end else if (cmd.take) begin
         iq_ff   <= iq_in;
         qs_ff   <= qs_in;
         fhc_ff  <= fhc_in;
         ls_ff   <= ls_in;
         ovf_ff  <= ovf_in;
         held_ff <= held_in;
      end else if (cmd.pop) begin
         held_ff <= held_ff - 1'b1;
      end
   end

   // Whitespace buffer: write at the fill position, drain from bit 0
   always_ff @(posedge clock) begin
      if (cmd.take && ws_wr) begin
         ws_ff[held_ff[IDX_W-1:0]] <= ws_bit;
      end else if (cmd.pop) begin
         ws_ff <= ws_ff >> 1;
      end
   end

   // Content byte latched while the flush runs
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         char_ff <= b;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((cmd.take && (kind == csvt_pkg::KIND_MARK
                                 || kind == csvt_pkg::KIND_CHAR))
                   || cmd.pop || cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         rsp_ff.out_char    <= ws_ff[0] ? csvt_pkg::CH_TAB : csvt_pkg::CH_SPACE;
         rsp_ff.has_char    <= 1'b1;
         rsp_ff.field_end   <= 1'b0;
         rsp_ff.row_end     <= 1'b0;
         rsp_ff.ws_overflow <= ovf_ff;
         rsp_ff.last        <= 1'b0;
      end else if (cmd.emit) begin
         rsp_ff.out_char    <= char_ff;
         rsp_ff.has_char    <= 1'b1;
         rsp_ff.field_end   <= 1'b0;
         rsp_ff.row_end     <= 1'b0;
         rsp_ff.ws_overflow <= ovf_ff;
         rsp_ff.last        <= 1'b1;
      end else if (cmd.take && kind == csvt_pkg::KIND_CHAR) begin
         rsp_ff.out_char    <= b;
         rsp_ff.has_char    <= 1'b1;
         rsp_ff.field_end   <= 1'b0;
         rsp_ff.row_end     <= 1'b0;
         rsp_ff.ws_overflow <= ovf_ff;
         rsp_ff.last        <= 1'b1;
      end else if (cmd.take && kind == csvt_pkg::KIND_MARK) begin
         rsp_ff.out_char    <= 8'd0;
         rsp_ff.has_char    <= 1'b0;
         rsp_ff.field_end   <= 1'b1;
         rsp_ff.row_end     <= mark_re;
         rsp_ff.ws_overflow <= ovf_ff;
         rsp_ff.last        <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/csvt_ctrl.sv
module csvt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  csvt_pkg::sts_type sts,
   output csvt_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FLUSH = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   logic [1:0] state_ff, state_in;

   // Items enter only in idle, when the output register can take a result
   assign req_stall = !(state_ff == ST_IDLE && sts.slot_free);
   assign cmd.take  = req_valid && !req_stall;
   assign cmd.pop   = (state_ff == ST_FLUSH) && sts.slot_free;
   assign cmd.emit  = (state_ff == ST_EMIT) && sts.slot_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.take && sts.kind == csvt_pkg::KIND_HELD) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (cmd.pop && sts.held_one) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.emit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: bench/tb_csv_field_tokenizer.sv
module tb_csv_field_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         HOLD_DEPTH       = 16;
   localparam int         WATCHDOG_LIMIT   = 2000;
   localparam int         SETTLE_CYCLES    = 6;
   localparam int         LONG_HOLD_CYCLES = 80;
   localparam logic [7:0] CH_CR            = 8'd13;
   // indexes that map to no register
   localparam logic [1:0] CSR_SPARE_A      = 2'd2;
   localparam logic [1:0] CSR_SPARE_B      = 2'd3;

   // Predicts the token stream and checks results in order
   class tokenizer_scoreboard;
      logic [7:0] delim;
      logic [7:0] quote;
      bit in_quoted;
      bit quote_pending;
      bit has_content;
      bit line_started;
      bit overflow;
      bit [HOLD_DEPTH-1:0] held_tab;
      int held_count;
      csvt_pkg::rsp_type step_out[$];
      csvt_pkg::rsp_type expected_q[$];
      int errors;
      int results_checked;
      int max_burst;

      function new();
         delim = csvt_pkg::DELIMITER_RESET;
         quote = csvt_pkg::QUOTE_RESET;
         in_quoted = 0;
         quote_pending = 0;
         has_content = 0;
         line_started = 0;
         overflow = 0;
         held_tab = '0;
         held_count = 0;
         errors = 0;
         results_checked = 0;
         max_burst = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [7:0] val);
         case (idx)
            csvt_pkg::CSR_DELIMITER: delim = val;
            csvt_pkg::CSR_QUOTE:     quote = val;
            default: ;
         endcase
      endfunction

      function void push_result(logic [7:0] ch, bit has, bit fe, bit re);
         csvt_pkg::rsp_type r;
         r = '0;
         r.out_char = ch;
         r.has_char = has;
         r.field_end = fe;
         r.row_end = re;
         step_out.insert(step_out.size(), r);
      endfunction

      function void clear_field();
         has_content = 0;
         held_count = 0;
      endfunction

      // flush held whitespace in order, then the content byte
      function void emit_content(logic [7:0] ch);
         for (int i = 0; i < held_count; i++)
            push_result(held_tab[i] ? csvt_pkg::CH_TAB : csvt_pkg::CH_SPACE, 1, 0, 0);
         held_count = 0;
         has_content = 1;
         push_result(ch, 1, 0, 0);
      endfunction

      // delimiter beats newline beats quote beats whitespace
      function void byte_outside(logic [7:0] b);
         if (b == delim) begin
            clear_field();
            line_started = 1;
            push_result(8'h00, 0, 1, 0);
         end else if (b == csvt_pkg::CH_NEWLINE) begin
            clear_field();
            line_started = 0;
            push_result(8'h00, 0, 1, 1);
         end else begin
            line_started = 1;
            if (b == quote) begin
               in_quoted = 1;
               has_content = 1;
            end else if (b == csvt_pkg::CH_SPACE || b == csvt_pkg::CH_TAB) begin
               if (has_content) begin
                  if (held_count < HOLD_DEPTH) begin
                     held_tab[held_count] = (b == csvt_pkg::CH_TAB);
                     held_count++;
                  end else begin
                     overflow = 1;
                  end
               end
            end else begin
               emit_content(b);
            end
         end
      endfunction

      function void note_input(csvt_pkg::req_type item);
         csvt_pkg::rsp_type r;
         step_out.delete();
         if (item.operation == csvt_pkg::OP_END) begin
            if (line_started)
               push_result(8'h00, 0, 1, 1);
            in_quoted = 0;
            quote_pending = 0;
            line_started = 0;
            clear_field();
         end else if (in_quoted && quote_pending) begin
            quote_pending = 0;
            line_started = 1;
            if (item.in_byte == quote) begin
               emit_content(item.in_byte);
            end else begin
               in_quoted = 0;
               byte_outside(item.in_byte);
            end
         end else if (in_quoted) begin
            line_started = 1;
            if (item.in_byte == quote)
               quote_pending = 1;
            else
               emit_content(item.in_byte);
         end else begin
            byte_outside(item.in_byte);
         end
         // overflow flag as it stands after the step, last on the final one
         for (int i = 0; i < step_out.size(); i++) begin
            r = step_out[i];
            r.ws_overflow = overflow;
            r.last = (i == step_out.size() - 1);
            expected_q.insert(expected_q.size(), r);
         end
         if (step_out.size() > max_burst)
            max_burst = step_out.size();
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(string what);
         errors++;
         $display("mismatch: %s", what);
      endtask

      task check(csvt_pkg::rsp_type got);
         csvt_pkg::rsp_type want;
         results_checked++;
         if (expected_q.size() == 0) begin
            report($sformatf("result %0d (%h) with nothing expected", results_checked, got));
            return;
         end
         want = expected_q.pop_front();
         if (got.out_char !== want.out_char)
            report($sformatf("result %0d out_char %h, want %h",
                             results_checked, got.out_char, want.out_char));
         if (got.has_char !== want.has_char)
            report($sformatf("result %0d has_char %b, want %b",
                             results_checked, got.has_char, want.has_char));
         if (got.field_end !== want.field_end)
            report($sformatf("result %0d field_end %b, want %b",
                             results_checked, got.field_end, want.field_end));
         if (got.row_end !== want.row_end)
            report($sformatf("result %0d row_end %b, want %b",
                             results_checked, got.row_end, want.row_end));
         if (got.ws_overflow !== want.ws_overflow)
            report($sformatf("result %0d ws_overflow %b, want %b",
                             results_checked, got.ws_overflow, want.ws_overflow));
         if (got.last !== want.last)
            report($sformatf("result %0d last %b, want %b",
                             results_checked, got.last, want.last));
      endtask
   endclass

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   csvt_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   csvt_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [csvt_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]        csr_data = '0;

   tokenizer_scoreboard sb;
   bit idle_on = 1;
   bit hold_req = 0;
   int items_sent = 0;
   int quiet_cycles = 0;

   csv_field_tokenizer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: random stall bursts, one long hold on request
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_req = 0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat (idle_on ? $urandom_range(1, 20) : 1) @(posedge clock);
         end
      end
   end

   // check each accepted result
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check(rsp_data);
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("[csv_field_tokenizer] ERROR");
         $finish;
      end
   end

   task automatic send_item(logic op, logic [7:0] b);
      csvt_pkg::req_type item;
      item.operation = op;
      item.in_byte = b;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(item);
      items_sent++;
   endtask

   task automatic send_byte(logic [7:0] b);
      send_item(csvt_pkg::OP_BYTE, b);
   endtask

   task automatic send_end(logic [7:0] b);
      send_item(csvt_pkg::OP_END, b);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   // stop sending, let every result drain and the block go idle
   task automatic quiesce();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(idx, val);
   endtask

   task automatic set_config(logic [7:0] d, logic [7:0] q);
      quiesce();
      write_csr(csvt_pkg::CSR_DELIMITER, d);
      write_csr(csvt_pkg::CSR_QUOTE, q);
      write_csr($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, 8'($urandom_range(0, 255)));
      csr_valid <= 1'b0;
   endtask

   // quoted field with random content, doubled quotes included
   task automatic quoted_field();
      int n;
      send_byte(sb.quote);
      n = $urandom_range(0, 5);
      repeat (n) begin
         case ($urandom_range(0, 5))
            0: send_byte(sb.delim);
            1: send_byte(csvt_pkg::CH_NEWLINE);
            2: send_byte(csvt_pkg::CH_SPACE);
            3: begin
               send_byte(sb.quote);
               send_byte(sb.quote);
            end
            default: send_byte(8'($urandom_range(97, 122)));
         endcase
      end
      send_byte(sb.quote);
   endtask

   // mostly CSV-shaped text with some raw bytes and end-of-input items
   task automatic run_random(int count, int ws_max);
      int target;
      int r;
      int n;
      target = items_sent + count;
      while (items_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 34)
            send_byte(8'($urandom_range(97, 122)));
         else if (r < 44)
            send_byte(sb.delim);
         else if (r < 51)
            send_byte(csvt_pkg::CH_NEWLINE);
         else if (r < 58)
            send_byte(sb.quote);
         else if (r < 72) begin
            n = $urandom_range(1, ws_max);
            repeat (n)
               send_byte($urandom_range(0, 1) ? csvt_pkg::CH_TAB : csvt_pkg::CH_SPACE);
         end else if (r < 82)
            send_byte(8'($urandom_range(0, 255)));
         else if (r < 85)
            send_byte(CH_CR);
         else if (r < 88)
            send_end(8'($urandom_range(0, 255)));
         else
            quoted_field();
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // leading whitespace dropped, inner flushed, trailing trimmed
      send_text(" \tab  c\t,");
      // quoted delimiter, newline and space, doubled quote, close then held space
      send_text("\"x,\n \"\"\" y");
      send_byte(CH_CR);
      send_byte(csvt_pkg::CH_NEWLINE);
      // byte extremes, then end of input on a started line
      send_byte(8'h00);
      send_byte(8'hFF);
      send_end(8'hFF);
      // empty line, then end of input with nothing started
      send_byte(csvt_pkg::CH_NEWLINE);
      send_end(8'h00);
      // end of input inside an open quote
      send_text("\"q");
      send_end(8'h5A);
      run_random(50, 6);

      set_config(8'd59, 8'd39);
      hold_req = 1;
      run_random(60, 6);

      set_config(8'h00, 8'hFF);
      run_random(40, 6);

      // overflow: twenty whitespace bytes behind content, then a flush
      set_config(8'hFF, 8'h00);
      send_byte("w");
      repeat (20) send_byte($urandom_range(0, 1) ? csvt_pkg::CH_TAB : csvt_pkg::CH_SPACE);
      send_byte("v");
      send_byte(csvt_pkg::CH_NEWLINE);
      run_random(40, 20);

      set_config(csvt_pkg::CH_TAB, csvt_pkg::CH_SPACE);
      run_random(30, 20);

      // back to defaults, no idling on either side
      set_config(csvt_pkg::DELIMITER_RESET, csvt_pkg::QUOTE_RESET);
      idle_on = 0;
      run_random(40, 10);

      quiesce();
      repeat (20) @(posedge clock);
      $display("%0d input items, %0d results checked over six delimiter/quote settings",
               items_sent, sb.results_checked);
      $display("largest burst from one item: %0d results; whitespace overflow %s",
               sb.max_burst, sb.overflow ? "reached" : "not reached");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[csv_field_tokenizer] OK");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
         $display("[csv_field_tokenizer] ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/csvt_pkg.sv
hdl/csvt_datapath.sv
hdl/csvt_ctrl.sv
hdl/csv_field_tokenizer.sv
bench/tb_csv_field_tokenizer.sv
